/* rtl/slcfp_pkg.sv */
// Package for the sync/length/CRC-8 frame parser: phase and readout state
// types, frame descriptor, register indexes and the CRC-8 byte update.
// No dependencies.
package slcfp_pkg;

   localparam int MAX_FRAME_PAYLOAD_DEFAULT = 32;

   localparam logic [7:0] SYNC_RESET  = 8'hAB;
   localparam logic [5:0] LIMIT_RESET = 6'd32;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_MSB     = 8'h80;

   // register indexes on the csr port
   localparam logic CSR_SYNC_VALUE   = 1'b0;
   localparam logic CSR_LENGTH_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_DATA
   } back_state_type;

   // one validated frame waiting for readout
   typedef struct packed {
      logic [7:0] frame_type;
      logic [5:0] frame_length;
      logic       bank;
   } frame_desc_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'd0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/slcfp_front.sv */
// Front end: sync hunt, header decode, CRC check and payload buffer writes.
// Pushes one descriptor per good frame into the queue. Uses slcfp_pkg.
module slcfp_front #(
   parameter int MAX_FRAME_PAYLOAD = slcfp_pkg::MAX_FRAME_PAYLOAD_DEFAULT,
   localparam int AW = (MAX_FRAME_PAYLOAD > 1) ? $clog2(MAX_FRAME_PAYLOAD) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [7:0]                 csr_data,
   input  logic                       q_full,
   output logic                       q_push,
   output slcfp_pkg::frame_desc_type  q_push_desc,
   output logic                       mem_wr_en,
   output logic [AW:0]                mem_wr_addr,
   output logic [7:0]                 mem_wr_data
);
   import slcfp_pkg::*;

   localparam logic [7:0] MAX_L = 8'(MAX_FRAME_PAYLOAD);

   phase_type  phase_ff, phase_in;
   logic [7:0] sync_ff;
   logic [5:0] limit_ff;
   logic [7:0] type_ff, type_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] fill_ff, fill_in;
   logic [7:0] crc_ff, crc_in;
   logic       bank_ff, bank_in;
   logic       accept;
   logic [5:0] fill_next;
   logic [7:0] fill_ext;
   logic [7:0] limit_eff;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign fill_next  = fill_ff + 6'd1;
   assign fill_ext   = {2'b00, fill_ff};
   assign limit_eff  = ({2'b00, limit_ff} > MAX_L) ? MAX_L : {2'b00, limit_ff};

   assign mem_wr_addr = {bank_ff, fill_ext[AW-1:0]};
   assign mem_wr_data = req_tdata;
   assign q_push_desc = '{frame_type: type_ff, frame_length: len_ff, bank: bank_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff  <= SYNC_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_VALUE:   sync_ff  <= csr_data;
            CSR_LENGTH_LIMIT: limit_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         type_ff  <= 8'd0;
         len_ff   <= 6'd0;
         fill_ff  <= 6'd0;
         crc_ff   <= 8'd0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         crc_ff   <= crc_in;
         bank_ff  <= bank_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      fill_in   = fill_ff;
      crc_in    = crc_ff;
      bank_in   = bank_ff;
      mem_wr_en = 1'b0;
      q_push    = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_tdata == sync_ff) phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               type_in  = req_tdata;
               crc_in   = crc8_update(8'd0, req_tdata);
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (req_tdata > limit_eff) begin
                  phase_in = PH_HUNT;
               end else begin
                  len_in   = req_tdata[5:0];
                  crc_in   = crc8_update(crc_ff, req_tdata);
                  fill_in  = 6'd0;
                  phase_in = (req_tdata == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               mem_wr_en = (fill_ext < MAX_L);
               crc_in    = crc8_update(crc_ff, req_tdata);
               fill_in   = fill_next;
               if (fill_next >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in = PH_HUNT;
               if (req_tdata == crc_ff) begin
                  q_push  = 1'b1;
                  bank_in = ~bank_ff;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

endmodule

/* rtl/slcfp_queue.sv */
// Two-entry descriptor queue between front and back; one entry per
// payload buffer bank. Uses slcfp_pkg.
module slcfp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  slcfp_pkg::frame_desc_type  push_desc,
   input  logic                       pop,
   output slcfp_pkg::frame_desc_type  head,
   output logic                       full,
   output logic                       empty
);
   import slcfp_pkg::*;

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff;

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("descriptor pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("descriptor popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

endmodule

/* rtl/slcfp_back.sv */
// Back end: two-bank payload memory and the readout sequencer that turns
// each queued descriptor into a run of result transfers. Uses slcfp_pkg.
module slcfp_back #(
   parameter int MAX_FRAME_PAYLOAD = slcfp_pkg::MAX_FRAME_PAYLOAD_DEFAULT,
   localparam int AW = (MAX_FRAME_PAYLOAD > 1) ? $clog2(MAX_FRAME_PAYLOAD) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mem_wr_en,
   input  logic [AW:0]                mem_wr_addr,
   input  logic [7:0]                 mem_wr_data,
   input  slcfp_pkg::frame_desc_type  q_head,
   input  logic                       q_empty,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tlast
);
   import slcfp_pkg::*;

   localparam int MEM_DEPTH = 2 << AW;

   logic [7:0]     mem [MEM_DEPTH];
   logic [7:0]     rd_data_ff;
   logic [AW:0]    rd_addr;

   back_state_type state_ff, state_in;
   logic [5:0]     idx_ff, idx_in;
   logic [5:0]     idx_next;
   logic [7:0]     idx_ext;
   logic           out_free, load, item_last;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_type_ff, rsp_payload_ff;
   logic [5:0]     rsp_length_ff;
   logic [4:0]     rsp_index_ff;
   logic           rsp_last_ff;

   assign idx_next  = idx_ff + 6'd1;
   assign idx_ext   = {2'b00, idx_ff};
   assign rd_addr   = {q_head.bank, idx_ext[AW-1:0]};
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign item_last = (q_head.frame_length == 6'd0) || (idx_next == q_head.frame_length);

   always_ff @(posedge clock) begin
      if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register: load a new item, hold it while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_type_ff    <= q_head.frame_type;
         rsp_length_ff  <= q_head.frame_length;
         rsp_index_ff   <= idx_ff[4:0];
         rsp_payload_ff <= (q_head.frame_length == 6'd0) ? 8'd0 : rd_data_ff;
         rsp_last_ff    <= item_last;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      load     = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               idx_in   = 6'd0;
               state_in = BK_READ;
            end
         end
         BK_READ: state_in = BK_DATA;
         BK_DATA: begin
            if (out_free) begin
               load = 1'b1;
               if (item_last) begin
                  q_pop    = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_next;
                  state_in = BK_READ;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_payload_ff, rsp_index_ff, rsp_length_ff, rsp_type_ff};

   a_busy_has_desc: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_IDLE) |-> !q_empty) else $error("readout without descriptor");

endmodule

/* rtl/sync_length_crc8_frame_parser_top.sv */
// Top level of the sync/type/length/payload/CRC-8 frame parser.
// Instantiates slcfp_front, slcfp_queue and slcfp_back; uses slcfp_pkg.
//
// Usage:
//   req_*  : one received link byte per transfer (req_tdata[7:0]).
//   rsp_*  : one payload byte of a validated frame per transfer; rsp_tlast
//            marks the final byte. A zero-length frame gives one transfer
//            with length 0, index 0 and payload 0.
//   csr_*  : register writes, index 0 = sync_value, 1 = length_limit
//            (low 6 bits taken). Always ready; write only while idle.
// Rate: the front takes one byte per cycle while the queue is not full. Readout
//   of a good frame starts once its descriptor is at the head of the queue; the
//   readout sequencer takes each item through address and memory read, then load.
// The queue holds two finished frames, one per payload memory bank; while
//   both banks are waiting for readout, req_tready is low.
// Reset: phase back to sync hunting, queue emptied, registers to their
//   defaults (sync 0xAB, limit 32). No memory clearing pass.
// Receiver stall: the output register holds the item, the readout pauses,
//   and the front keeps accepting bytes until the queue fills.
module sync_length_crc8_frame_parser_top #(
   parameter int MAX_FRAME_PAYLOAD = slcfp_pkg::MAX_FRAME_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] frame_type, [13:8] frame_length,
                                     // [18:14] byte_index, [26:19] payload_byte
   output logic        rsp_tlast,    // last
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import slcfp_pkg::*;

   localparam int AW = (MAX_FRAME_PAYLOAD > 1) ? $clog2(MAX_FRAME_PAYLOAD) : 1;

   // front to queue
   logic           q_push, q_pop, q_full, q_empty;
   frame_desc_type q_push_desc, q_head;
   // front to payload memory
   logic           mem_wr_en;
   logic [AW:0]    mem_wr_addr;
   logic [7:0]     mem_wr_data;

   // hunt, decode, check and buffer the incoming bytes
   slcfp_front #(.MAX_FRAME_PAYLOAD(MAX_FRAME_PAYLOAD)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_desc (q_push_desc),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // hold validated frames until the back end reads them out
   slcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // read out the buffered payload one item at a time
   slcfp_back #(.MAX_FRAME_PAYLOAD(MAX_FRAME_PAYLOAD)) u_back (
      .clock       (clock),
      .reset       (reset),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* test/slcfp_scoreboard_pkg.sv */
// Scoreboard for the sync/length/CRC-8 frame parser testbench: a deframer
// predictor that turns accepted link bytes into expected payload transfers.
// Depends on slcfp_pkg for the phase type, register indexes and constants.
package slcfp_scoreboard_pkg;
   import slcfp_pkg::*;

   localparam int PAYLOAD_DEPTH = MAX_FRAME_PAYLOAD_DEFAULT;
   localparam int PAYLOAD_AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [7:0] frame_type;
      logic [5:0] frame_length;
      logic [4:0] byte_index;
      logic [7:0] payload_byte;
      logic       last;
   } frame_item_type;

   class frame_scoreboard;
      logic [7:0]     sync_byte;
      logic [5:0]     len_cap;
      phase_type      ph;
      logic [7:0]     hold_type;
      logic [5:0]     hold_len;
      logic [5:0]     fill;
      logic [7:0]     crc;
      logic [7:0]     payload_mem[PAYLOAD_DEPTH];
      frame_item_type expected_items[$];
      int             mismatches;
      int             transfers;
      int             frames_good;

      function new();
         sync_byte   = SYNC_RESET;
         len_cap     = LIMIT_RESET;
         ph          = PH_HUNT;
         hold_type   = '0;
         hold_len    = '0;
         fill        = '0;
         crc         = '0;
         mismatches  = 0;
         transfers   = 0;
         frames_good = 0;
      endfunction

      // bit-serial CRC-8, MSB first, init taken from the caller
      static function logic [7:0] crc_byte(logic [7:0] seed, logic [7:0] b);
         logic [7:0] r;
         r = seed;
         for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ b[i]) begin
               r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
               r = {r[6:0], 1'b0};
            end
         end
         return r;
      endfunction

      function int effective_limit();
         return (int'(len_cap) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(len_cap);
      endfunction

      function void set_register(logic idx, logic [7:0] val);
         if (idx == CSR_SYNC_VALUE) begin
            sync_byte = val;
         end else begin
            len_cap = val[5:0];
         end
      endfunction

      function int pending();
         return expected_items.size();
      endfunction

      // advance the deframer by one accepted link byte
      function void note_link_byte(logic [7:0] b);
         frame_item_type item;
         case (ph)
            PH_HUNT: begin
               if (b == sync_byte) ph = PH_TYPE;
            end
            PH_TYPE: begin
               hold_type = b;
               crc       = crc_byte(8'h00, b);
               ph        = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (int'(b) > effective_limit()) begin
                  ph = PH_HUNT;
               end else begin
                  hold_len = b[5:0];
                  crc      = crc_byte(crc, b);
                  fill     = '0;
                  ph       = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (int'(fill) < PAYLOAD_DEPTH) payload_mem[fill[PAYLOAD_AW-1:0]] = b;
               crc  = crc_byte(crc, b);
               fill = fill + 6'd1;
               if (fill >= hold_len) ph = PH_CHECK;
            end
            PH_CHECK: begin
               ph = PH_HUNT;
               if (b == crc) begin
                  frames_good++;
                  if (hold_len == 6'd0) begin
                     item.frame_type   = hold_type;
                     item.frame_length = '0;
                     item.byte_index   = '0;
                     item.payload_byte = '0;
                     item.last         = 1'b1;
                     expected_items.push_back(item);
                  end else begin
                     for (int k = 0; k < int'(hold_len) && k < PAYLOAD_DEPTH; k++) begin
                        item.frame_type   = hold_type;
                        item.frame_length = hold_len;
                        item.byte_index   = 5'(k);
                        item.payload_byte = payload_mem[k];
                        item.last         = (k + 1 == int'(hold_len));
                        expected_items.push_back(item);
                     end
                  end
               end
            end
            default: ph = PH_HUNT;
         endcase
      endfunction

      // compare one result transfer with the oldest expected item
      function void check_item(logic [31:0] data, logic last_bit);
         frame_item_type got;
         frame_item_type want;
         logic           bad;
         got.frame_type   = data[7:0];
         got.frame_length = data[13:8];
         got.byte_index   = data[18:14];
         got.payload_byte = data[26:19];
         got.last         = last_bit;
         transfers++;
         if (expected_items.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected transfer: type %02h len %0d idx %0d byte %02h last %0b",
                        got.frame_type, got.frame_length, got.byte_index,
                        got.payload_byte, got.last);
            return;
         end
         want = expected_items.pop_front();
         bad  = (got.frame_type   !== want.frame_type)   ||
                (got.frame_length !== want.frame_length) ||
                (got.byte_index   !== want.byte_index)   ||
                (got.payload_byte !== want.payload_byte) ||
                (got.last         !== want.last);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("transfer %0d expected: type %02h len %0d idx %0d byte %02h last %0b",
                        transfers, want.frame_type, want.frame_length, want.byte_index,
                        want.payload_byte, want.last);
               $display("transfer %0d actual:   type %02h len %0d idx %0d byte %02h last %0b",
                        transfers, got.frame_type, got.frame_length, got.byte_index,
                        got.payload_byte, got.last);
            end
         end
      endfunction
   endclass

endpackage

/* test/tb_sync_length_crc8_frame_parser_top.sv */
// Testbench top for sync_length_crc8_frame_parser_top: drives link bytes,
// register writes and result back-pressure, and checks every payload transfer.
// Depends on slcfp_pkg and slcfp_scoreboard_pkg.
module tb_sync_length_crc8_frame_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slcfp_pkg::*;
   import slcfp_scoreboard_pkg::*;

   // cycles without any transfer before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // settling time after the last predicted item has arrived; allow margin
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_BYTES   = 18;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;     // [7:0] frame_type, [13:8] frame_length,
                               // [18:14] byte_index, [26:19] payload_byte
   logic        rsp_tlast;     // last
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   frame_scoreboard sb = new();

   // idle percentages for the sender and the receiver, changed per phase
   int send_idle  = 0;
   int recv_stall = 0;
   int bytes_sent = 0;
   int settings   = 0;
   int idle_count = 0;

   // payload of the frame being built by the stimulus tasks
   logic [7:0] payload_q[$];

   sync_length_crc8_frame_parser_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure: draw a fresh ready every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
   end

   // Check each result transfer against the oldest predicted item.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_item(rsp_tdata, rsp_tlast);
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset) begin
         idle_count <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d items still due",
                  idle_count, sb.pending());
         $display("Mismatches found");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // Send one link byte. Drop valid only when a gap is drawn, so valid is
   // never lowered and raised within the same step.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_link_byte(b);
      bytes_sent++;
   endtask

   // Send sync, type, length, payload_q and, if asked, the check byte
   // xor-ed with crc_flip (nonzero flip corrupts the frame).
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                             input logic [7:0] crc_flip, input logic with_check);
      logic [7:0] crc;
      crc = frame_scoreboard::crc_byte(8'h00, ftype);
      crc = frame_scoreboard::crc_byte(crc, flen);
      send_byte(sb.sync_byte);
      send_byte(ftype);
      send_byte(flen);
      foreach (payload_q[i]) begin
         send_byte(payload_q[i]);
         crc = frame_scoreboard::crc_byte(crc, payload_q[i]);
      end
      if (with_check) send_byte(crc ^ crc_flip);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every predicted item has arrived, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed frames with random content; the rest are corrupted
   // checks, over-long lengths and loose noise bytes.
   task automatic random_traffic(input int n_bytes);
      int         start;
      int         r;
      int         cap;
      int         flen;
      logic [7:0] ftype;
      start = bytes_sent;
      cap   = sb.effective_limit();
      while (bytes_sent - start < n_bytes) begin
         r     = $urandom_range(0, 99);
         ftype = 8'($urandom);
         payload_q.delete();
         if (r < 80) begin
            flen = ($urandom_range(0, 7) == 0) ? cap : $urandom_range(0, (cap < 6) ? cap : 6);
            repeat (flen)
               payload_q.push_back(($urandom_range(0, 9) == 0) ? sb.sync_byte : 8'($urandom));
            send_frame(ftype, 8'(flen), (r < 68) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b1);
         end else if (r < 88) begin
            send_frame(ftype, 8'($urandom_range(cap + 1, 255)), 8'h00, 1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
      end
      // finish any frame left open so the next register write sees hunting
      while (sb.ph != PH_HUNT) send_byte(8'($urandom));
   endtask

   task automatic run_phase(input logic [7:0] sync, input logic [5:0] limit,
                            input int send_pct, input int recv_pct);
      drain();
      write_reg(CSR_SYNC_VALUE, sync);
      write_reg(CSR_LENGTH_LIMIT, {2'($urandom_range(0, 3)), limit});
      settings++;
      send_idle  = send_pct;
      recv_stall = recv_pct;
      random_traffic(RANDOM_BYTES);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_SYNC_VALUE;
      csr_data   <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings: noise, a frame holding the sync
      // value and both byte extremes, an empty frame, an over-long length
      // and a corrupted check byte.
      settings = 1;
      send_byte(8'h00);
      payload_q = '{8'hAB, 8'h00, 8'hFF};
      send_frame(8'h00, 8'd3, 8'h00, 1'b1);
      payload_q.delete();
      send_frame(8'hFF, 8'd0, 8'h00, 1'b1);
      send_frame(8'h12, 8'hFF, 8'h00, 1'b0);
      payload_q = '{8'h5C};
      send_frame(8'h80, 8'd1, 8'h01, 1'b1);

      // Limit above the buffer: length 33 must still be dropped. Sync of
      // zero also makes a zero type byte look like sync inside the frame.
      drain();
      write_reg(CSR_SYNC_VALUE, 8'h00);
      write_reg(CSR_LENGTH_LIMIT, 8'd63);
      settings++;
      payload_q.delete();
      send_frame(8'h7F, 8'd33, 8'h00, 1'b0);
      send_frame(8'h00, 8'd0, 8'h00, 1'b1);
      random_traffic(RANDOM_BYTES);

      run_phase(8'hFF, 6'd0,  84, 0);
      run_phase(8'h5A, 6'd20, 0,  84);
      run_phase(8'hAB, 6'd32, 33, 33);
      drain();

      if (sb.pending() != 0) sb.mismatches += sb.pending();
      $display("Run covered %0d link bytes over %0d register settings and four idle profiles;",
               bytes_sent, settings);
      $display("%0d frames passed their check, %0d payload transfers compared.",
               sb.frames_good, sb.transfers);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
